[rtl/tfn_pkg.sv]
// Shared widths and pipeline payload types for the triangle face normal unit.
// No dependencies; used by tfn_front, tfn_root_step and triangle_face_normal_unit.
package tfn_pkg;

	// Coordinate, edge, partial product and cross product widths.
	localparam int CW  = 16;
	localparam int EW  = CW + 1;
	localparam int PRW = 2 * EW;
	localparam int NW  = PRW + 1;

	// Square of one component, sum of the three squares.
	localparam int SQW = 2 * NW - 3;
	localparam int SW  = SQW + 1;

	// Scale shift of the squared component, quotient bits, residual widths.
	localparam int RSH = 30;
	localparam int QW  = 15;
	localparam int PW  = SW + QW + 2;
	localparam int DW  = SW + 2 * QW + 4;

	// Front end result: degenerate flag, squares, their sum and the component signs.
	typedef struct packed {
		logic                  degen;
		logic [SW-1:0]         s;
		logic [2:0][SQW-1:0]   sq;
		logic [2:0]            neg;
	} tfn_front_t;

	// Per-component state of the digit-by-digit quotient search.
	typedef struct packed {
		logic signed [DW-1:0]  d;
		logic signed [PW-1:0]  p;
		logic [QW-1:0]         q;
		logic                  neg;
	} tfn_comp_t;

	// Payload that travels down the quotient search stages.
	typedef struct packed {
		logic                  degen;
		logic [SW-1:0]         s;
		tfn_comp_t [2:0]       c;
	} tfn_root_t;

endpackage

[rtl/tfn_front.sv]
// Front end of the normal pipeline: edges, cross product, squares and their sum.
// Five register stages; depends on tfn_pkg.
module tfn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [tfn_pkg::CW-1:0] ax,
	input  logic signed [tfn_pkg::CW-1:0] ay,
	input  logic signed [tfn_pkg::CW-1:0] az,
	input  logic signed [tfn_pkg::CW-1:0] bx,
	input  logic signed [tfn_pkg::CW-1:0] by_coord,
	input  logic signed [tfn_pkg::CW-1:0] bz,
	input  logic signed [tfn_pkg::CW-1:0] cx,
	input  logic signed [tfn_pkg::CW-1:0] cy,
	input  logic signed [tfn_pkg::CW-1:0] cz,
	output logic                          out_vld,
	output tfn_pkg::tfn_front_t           out_data
);

	logic                            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [tfn_pkg::EW-1:0]   e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [tfn_pkg::PRW-1:0]  pa_s2 [3];
	logic signed [tfn_pkg::PRW-1:0]  pb_s2 [3];
	logic signed [tfn_pkg::NW-1:0]   n_s3 [3];
	logic signed [2*tfn_pkg::NW-1:0] sqf [3];
	logic [tfn_pkg::SQW-1:0]         sq_s4 [3];
	logic [2:0]                      neg_s4, zero_s4;
	tfn_pkg::tfn_front_t             front_s5;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: edge vectors from the first vertex at full width.
	always_ff @(posedge clk) begin
		e1x_s1 <= tfn_pkg::EW'(bx) - tfn_pkg::EW'(ax);
		e1y_s1 <= tfn_pkg::EW'(by_coord) - tfn_pkg::EW'(ay);
		e1z_s1 <= tfn_pkg::EW'(bz) - tfn_pkg::EW'(az);
		e2x_s1 <= tfn_pkg::EW'(cx) - tfn_pkg::EW'(ax);
		e2y_s1 <= tfn_pkg::EW'(cy) - tfn_pkg::EW'(ay);
		e2z_s1 <= tfn_pkg::EW'(cz) - tfn_pkg::EW'(az);
	end

	// Stage 2: the six partial products of the cross product.
	always_ff @(posedge clk) begin
		pa_s2[0] <= e1y_s1 * e2z_s1;
		pb_s2[0] <= e1z_s1 * e2y_s1;
		pa_s2[1] <= e1z_s1 * e2x_s1;
		pb_s2[1] <= e1x_s1 * e2z_s1;
		pa_s2[2] <= e1x_s1 * e2y_s1;
		pb_s2[2] <= e1y_s1 * e2x_s1;
	end

	// Stage 3: cross product components, exact.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s3[i] <= tfn_pkg::NW'(pa_s2[i]) - tfn_pkg::NW'(pb_s2[i]);
		end
	end

	// Stage 4: squares of the components, with sign and zero flags.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqf[i] = n_s3[i] * n_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i]   <= sqf[i][tfn_pkg::SQW-1:0];
			neg_s4[i]  <= n_s3[i][tfn_pkg::NW-1];
			zero_s4[i] <= (n_s3[i] == '0);
		end
	end

	// Stage 5: squared length of the normal.
	always_ff @(posedge clk) begin
		front_s5.s     <= tfn_pkg::SW'(sq_s4[0]) + tfn_pkg::SW'(sq_s4[1])
			+ tfn_pkg::SW'(sq_s4[2]);
		front_s5.degen <= &zero_s4;
		front_s5.neg   <= neg_s4;
		for (int i = 0; i < 3; i++) begin
			front_s5.sq[i] <= sq_s4[i];
		end
	end

	assign out_vld  = vld_s5;
	assign out_data = front_s5;

endmodule

[rtl/tfn_root_step.sv]
// One stage of the quotient search: decides quotient bit K for all three components.
// Depends on tfn_pkg.
module tfn_root_step #(
	parameter int K = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  tfn_pkg::tfn_root_t in_data,
	output logic               out_vld,
	output tfn_pkg::tfn_root_t out_data
);

	tfn_pkg::tfn_root_t            nxt;
	logic signed [tfn_pkg::PW-1:0] u [3];
	logic signed [tfn_pkg::DW-1:0] t [3];
	logic signed [tfn_pkg::DW-1:0] dn [3];
	logic                          acc [3];
	logic                          vld_s1;
	tfn_pkg::tfn_root_t            data_s1;

	// The residual d holds rhs - s*(2q-1)^2 and p holds s*(2q-1). Setting bit K
	// of q grows s*t^2 by ((p + s*2^K) * 2^(K+2)); the bit stays when the new
	// residual is not negative.
	always_comb begin
		nxt = in_data;
		for (int i = 0; i < 3; i++) begin
			u[i]   = in_data.c[i].p + $signed(tfn_pkg::PW'(in_data.s) << K);
			t[i]   = tfn_pkg::DW'(u[i]) << (K + 2);
			dn[i]  = in_data.c[i].d - t[i];
			acc[i] = !dn[i][tfn_pkg::DW-1];
			if (acc[i]) begin
				nxt.c[i].d = dn[i];
				nxt.c[i].p = in_data.c[i].p + $signed(tfn_pkg::PW'(in_data.s) << (K + 1));
				nxt.c[i].q = in_data.c[i].q | (tfn_pkg::QW'(1) << K);
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

[rtl/triangle_face_normal_unit.sv]
// Triangle face normal unit: unit normal of one triangle per clock cycle.
//
// Input channel: a triangle (ax..cz, signed Q8.8) is transferred at each rising
// edge where start is high and busy is low. busy is always low, so a new
// triangle may be started in every cycle.
// Output channel: done is high for exactly one cycle with unit_x, unit_y,
// unit_z (signed Q1.14, rounded to nearest, ties away from zero) and
// degenerate. A degenerate triangle (zero cross product) gives zeros and
// degenerate high. The receiver cannot stall; results come in input order.
// From the start transfer to done a triangle passes five front end stages
// (edges, partial products, cross product, squares, sum), one stage to set up
// the search, one search stage for each of the 15 quotient bits, and one output stage.
// Throughput is one triangle per cycle; each search stage holds its own
// wide adder, so no unit is shared between triangles.
// Reset clears all valid bits, so no done strobe appears until triangles
// started after reset reach the end of the pipeline.
// Depends on tfn_pkg, tfn_front and tfn_root_step.
module triangle_face_normal_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [tfn_pkg::CW-1:0] ax,
	input  logic signed [tfn_pkg::CW-1:0] ay,
	input  logic signed [tfn_pkg::CW-1:0] az,
	input  logic signed [tfn_pkg::CW-1:0] bx,
	input  logic signed [tfn_pkg::CW-1:0] by_coord,
	input  logic signed [tfn_pkg::CW-1:0] bz,
	input  logic signed [tfn_pkg::CW-1:0] cx,
	input  logic signed [tfn_pkg::CW-1:0] cy,
	input  logic signed [tfn_pkg::CW-1:0] cz,
	output logic                          done,
	output logic signed [tfn_pkg::CW-1:0] unit_x,
	output logic signed [tfn_pkg::CW-1:0] unit_y,
	output logic signed [tfn_pkg::CW-1:0] unit_z,
	output logic                          degenerate
);

	localparam int LATENCY = 5 + 1 + tfn_pkg::QW + 1;

	logic                          front_vld;
	tfn_pkg::tfn_front_t           front_data;
	logic                          vld_s6;
	tfn_pkg::tfn_root_t            root_s6;
	logic                          stg_vld [tfn_pkg::QW+1];
	tfn_pkg::tfn_root_t            stg [tfn_pkg::QW+1];
	logic [tfn_pkg::CW-1:0]        val [3];
	logic                          done_q;
	logic                          degen_q;
	logic [tfn_pkg::CW-1:0]        unit_q [3];

	assign busy = 1'b0;

	// Cross product and squared length.
	tfn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start & ~busy),
		.ax       (ax),
		.ay       (ay),
		.az       (az),
		.bx       (bx),
		.by_coord (by_coord),
		.bz       (bz),
		.cx       (cx),
		.cy       (cy),
		.cz       (cz),
		.out_vld  (front_vld),
		.out_data (front_data)
	);

	// Search setup: q = 0 stands for t = -1, so d = n^2 * 2^30 - s and p = -s.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= front_vld;
		end
	end

	always_ff @(posedge clk) begin
		root_s6.degen <= front_data.degen;
		root_s6.s     <= front_data.s;
		for (int i = 0; i < 3; i++) begin
			root_s6.c[i].d   <= tfn_pkg::DW'({front_data.sq[i], tfn_pkg::RSH'(0)})
				- tfn_pkg::DW'(front_data.s);
			root_s6.c[i].p   <= -tfn_pkg::PW'(front_data.s);
			root_s6.c[i].q   <= '0;
			root_s6.c[i].neg <= front_data.neg[i];
		end
	end

	assign stg_vld[0] = vld_s6;
	assign stg[0]     = root_s6;

	// One stage for each quotient bit, most significant first.
	for (genvar j = 0; j < tfn_pkg::QW; j++) begin : g_step
		tfn_root_step #(
			.K (tfn_pkg::QW - 1 - j)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (stg_vld[j]),
			.in_data  (stg[j]),
			.out_vld  (stg_vld[j+1]),
			.out_data (stg[j+1])
		);
	end

	// Output stage: apply the sign, force zeros for a degenerate triangle.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (stg[tfn_pkg::QW].degen) begin
				val[i] = '0;
			end else if (stg[tfn_pkg::QW].c[i].neg) begin
				val[i] = -tfn_pkg::CW'(stg[tfn_pkg::QW].c[i].q);
			end else begin
				val[i] = tfn_pkg::CW'(stg[tfn_pkg::QW].c[i].q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stg_vld[tfn_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		degen_q <= stg[tfn_pkg::QW].degen;
		for (int i = 0; i < 3; i++) begin
			unit_q[i] <= val[i];
		end
	end

	assign done       = done_q;
	assign degenerate = degen_q;
	assign unit_x     = unit_q[0];
	assign unit_y     = unit_q[1];
	assign unit_z     = unit_q[2];

`ifndef SYNTHESIS
	// Every started triangle comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("started triangle did not complete after the pipeline latency");

	// A degenerate result carries a zero vector.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> unit_x == 0 && unit_y == 0 && unit_z == 0)
		else $error("degenerate result with a nonzero vector");

	// Components of a unit vector stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> unit_x <= 16384 && unit_x >= -16384 && unit_y <= 16384
			&& unit_y >= -16384 && unit_z <= 16384 && unit_z >= -16384)
		else $error("normal component out of range");

	// A valid normal is never the zero vector.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> unit_x != 0 || unit_y != 0 || unit_z != 0)
		else $error("nondegenerate result with a zero vector");
`endif

endmodule
